// File: rtl/bis_pkg.sv
`default_nettype none
package bis_pkg;

  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 256;
  localparam int CHANNELS = 4;

  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int PIX_W = CHANNELS * 8;

  // The frame is split into four banks by row and column parity.
  localparam int BANK_ROWS  = (MAX_ROWS + 1) / 2;
  localparam int BANK_COLS  = (MAX_COLS + 1) / 2;
  localparam int BANK_DEPTH = BANK_ROWS * BANK_COLS;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  typedef enum logic [2:0] {
    CFG_SRC_ROWS = 3'd0,
    CFG_SRC_COLS = 3'd1,
    CFG_TGT_ROWS = 3'd2,
    CFG_TGT_COLS = 3'd3,
    CFG_ROW_STEP = 3'd4,
    CFG_COL_STEP = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic row_en;
    logic copy;
  } lane_ctl_t;

  typedef struct packed {
    logic load;
    logic err;
  } merge_ctl_t;

endpackage
`default_nettype wire

// File: rtl/bis_ram.sv
`default_nettype none
module bis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/bis_lane.sv
`default_nettype none
module bis_lane (
  input  wire logic                clk,
  input  wire bis_pkg::lane_ctl_t  ctl,
  input  wire logic [15:0]         frac_row,
  input  wire logic [15:0]         frac_col,
  input  wire logic [7:0]          p00,
  input  wire logic [7:0]          p10,
  input  wire logic [7:0]          p01,
  input  wire logic [7:0]          p11,
  output logic      [7:0]          value
);

  logic [7:0] top_r, bot_r, base_r;
  logic [7:0] top_nxt, bot_nxt;

  logic signed [8:0]  d_top, d_bot, d_col;
  logic signed [25:0] m_top, m_bot, m_col;
  logic signed [9:0]  s_top, s_bot, s_col;

  // A blend (1-f)*a + f*b, truncated, equals a + floor(f*(b-a)).
  always_comb begin
    d_top   = $signed({1'b0, p10}) - $signed({1'b0, p00});
    d_bot   = $signed({1'b0, p11}) - $signed({1'b0, p01});
    m_top   = $signed({1'b0, frac_row}) * d_top;
    m_bot   = $signed({1'b0, frac_row}) * d_bot;
    s_top   = $signed({2'b00, p00}) + $signed(m_top[25:16]);
    s_bot   = $signed({2'b00, p01}) + $signed(m_bot[25:16]);
    top_nxt = s_top[7:0];
    bot_nxt = s_bot[7:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.row_en) begin
      top_r  <= top_nxt;
      bot_r  <= bot_nxt;
      base_r <= p00;
    end
  end

  always_comb begin
    d_col = $signed({1'b0, bot_r}) - $signed({1'b0, top_r});
    m_col = $signed({1'b0, frac_col}) * d_col;
    s_col = $signed({2'b00, top_r}) + $signed(m_col[25:16]);
    value = ctl.copy ? base_r : s_col[7:0];
  end

endmodule
`default_nettype wire

// File: rtl/bis_merge.sv
`default_nettype none
module bis_merge (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bis_pkg::merge_ctl_t ctl,
  input  wire logic [7:0]          lane_val [bis_pkg::CHANNELS],
  input  wire logic                out_stall,
  output logic                     ready,
  output logic                     out_valid,
  output logic      [7:0]          out_chan0,
  output logic      [7:0]          out_chan1,
  output logic      [7:0]          out_chan2,
  output logic      [7:0]          out_chan3,
  output logic                     out_range_error
);

  logic [7:0] chan_nxt [4];
  logic [7:0] chan_r   [4];
  logic       err_r;
  logic       valid_r, valid_nxt;

  // Channels beyond the stored ones, and every channel of an error word, read zero.
  for (genvar k = 0; k < 4; k++) begin : g_ch
    if (k < bis_pkg::CHANNELS) begin : g_used
      assign chan_nxt[k] = ctl.err ? 8'd0 : lane_val[k];
    end else begin : g_unused
      assign chan_nxt[k] = 8'd0;
    end
  end

  assign ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (ready) begin
      valid_nxt = ctl.load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && ctl.load) begin
      chan_r <= chan_nxt;
      err_r  <= ctl.err;
    end
  end

  assign out_valid       = valid_r;
  assign out_chan0       = chan_r[0];
  assign out_chan1       = chan_r[1];
  assign out_chan2       = chan_r[2];
  assign out_chan3       = chan_r[3];
  assign out_range_error = err_r;

endmodule
`default_nettype wire

// File: rtl/bilinear_image_scaler.sv
`default_nettype none
// Bilinear image scaler with a four-bank frame store.
//
// Input channel (in_valid / in_stall): a word with in_func = 0 loads one source
// pixel at (in_row, in_col); loads off the store are dropped. A word with
// in_func = 1 requests the output pixel at (in_row, in_col) and yields exactly
// one result word on the out_ channel; loads yield none.
// A load is written to the store as it is taken. A request then passes through
// the datapath steps in order (position multiply, address clamp and bank read,
// row blend, column blend into the output register); no new word is taken
// until the request leaves the column blend. in_stall stays high while a
// request is in flight; the 2x2 parity banks let all four neighbours be read
// in the same cycle.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready
// and must only be written while no request is in flight.
// Reset (rst_n low, synchronous) restores the register defaults and empties
// the datapath and output register; the frame store keeps no reset value.
// When the receiver stalls, the finished word holds in the output register,
// loads and a new request are still taken, and that request waits at the
// column blend until the register frees up.
module bilinear_image_scaler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic [11:0] in_row,
  input  wire logic [11:0] in_col,
  input  wire logic [7:0]  in_chan0,
  input  wire logic [7:0]  in_chan1,
  input  wire logic [7:0]  in_chan2,
  input  wire logic [7:0]  in_chan3,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [7:0]  out_chan0,
  output logic      [7:0]  out_chan1,
  output logic      [7:0]  out_chan2,
  output logic      [7:0]  out_chan3,
  output logic             out_range_error,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_POS   = 5'b00010,
    S_ADDR  = 5'b00100,
    S_READ  = 5'b01000,
    S_BLEND = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [8:0]  src_rows_r, src_cols_r;
  logic [11:0] tgt_rows_r, tgt_cols_r;
  logic [19:0] row_step_r, col_step_r;

  logic [11:0] row_r, col_r;
  logic        err_r;
  logic [31:0] pr_r, pc_r;
  logic        copy_r, r0p_r, c0p_r;

  logic        accept, load_we, merge_ready;
  logic [bis_pkg::PIX_W-1:0] wdata;
  logic [7:0]  chans [4];

  logic [15:0] last_r16, last_c16, r0_16, c0_16, r1_16, c1_16;
  logic [bis_pkg::ROW_W-1:0] r0_w, r1_w;
  logic [bis_pkg::COL_W-1:0] c0_w, c1_w;

  logic [bis_pkg::PIX_W-1:0] rd [4];
  logic [7:0] lane_val [bis_pkg::CHANNELS];
  bis_pkg::lane_ctl_t  lane_ctl;
  bis_pkg::merge_ctl_t merge_ctl;

  function automatic logic [bis_pkg::BANK_AW-1:0] bank_addr(
    input logic [bis_pkg::ROW_W-1:0] r,
    input logic [bis_pkg::COL_W-1:0] c
  );
    bank_addr = bis_pkg::BANK_AW'(int'(r >> 1) * bis_pkg::BANK_COLS + int'(c >> 1));
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign load_we   = accept && !in_func &&
                     (int'(in_row) < bis_pkg::MAX_ROWS) && (int'(in_col) < bis_pkg::MAX_COLS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_rows_r <= 9'd256;
      src_cols_r <= 9'd256;
      tgt_rows_r <= 12'd256;
      tgt_cols_r <= 12'd256;
      row_step_r <= 20'd65536;
      col_step_r <= 20'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (bis_pkg::cfg_idx_t'(cfg_index))
        bis_pkg::CFG_SRC_ROWS: src_rows_r <= cfg_data[8:0];
        bis_pkg::CFG_SRC_COLS: src_cols_r <= cfg_data[8:0];
        bis_pkg::CFG_TGT_ROWS: tgt_rows_r <= cfg_data[11:0];
        bis_pkg::CFG_TGT_COLS: tgt_cols_r <= cfg_data[11:0];
        bis_pkg::CFG_ROW_STEP: row_step_r <= cfg_data;
        bis_pkg::CFG_COL_STEP: col_step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept && in_func) state_nxt = S_POS;
      S_POS:   state_nxt = S_ADDR;
      S_ADDR:  state_nxt = S_READ;
      S_READ:  state_nxt = S_BLEND;
      S_BLEND: if (merge_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_func) begin
      row_r <= in_row;
      col_r <= in_col;
      err_r <= (in_row >= tgt_rows_r) || (in_col >= tgt_cols_r);
    end
    if (state_r == S_POS) begin
      pr_r <= 32'(row_r) * 32'(row_step_r);
      pc_r <= 32'(col_r) * 32'(col_step_r);
    end
    if (state_r == S_ADDR) begin
      copy_r <= (r0_16 == r1_16) || (c0_16 == c1_16);
      r0p_r  <= r0_w[0];
      c0p_r  <= c0_w[0];
    end
  end

  // A source size of zero counts as one; sizes past the store clamp to it.
  always_comb begin
    if (src_rows_r == 9'd0) begin
      last_r16 = 16'd0;
    end else if (int'(src_rows_r) > bis_pkg::MAX_ROWS) begin
      last_r16 = 16'(bis_pkg::MAX_ROWS - 1);
    end else begin
      last_r16 = 16'(src_rows_r) - 16'd1;
    end
    if (src_cols_r == 9'd0) begin
      last_c16 = 16'd0;
    end else if (int'(src_cols_r) > bis_pkg::MAX_COLS) begin
      last_c16 = 16'(bis_pkg::MAX_COLS - 1);
    end else begin
      last_c16 = 16'(src_cols_r) - 16'd1;
    end
    r0_16 = (pr_r[31:16] > last_r16) ? last_r16 : pr_r[31:16];
    c0_16 = (pc_r[31:16] > last_c16) ? last_c16 : pc_r[31:16];
    r1_16 = r0_16 + 16'(pr_r[15:0] != 16'd0);
    c1_16 = c0_16 + 16'(pc_r[15:0] != 16'd0);
    if (r1_16 > last_r16) r1_16 = last_r16;
    if (c1_16 > last_c16) c1_16 = last_c16;
    r0_w = r0_16[bis_pkg::ROW_W-1:0];
    r1_w = r1_16[bis_pkg::ROW_W-1:0];
    c0_w = c0_16[bis_pkg::COL_W-1:0];
    c1_w = c1_16[bis_pkg::COL_W-1:0];
  end

  assign chans = '{in_chan0, in_chan1, in_chan2, in_chan3};

  always_comb begin
    wdata = '0;
    for (int k = 0; k < bis_pkg::CHANNELS; k++) begin
      wdata[8*k +: 8] = chans[k];
    end
  end

  // Bank index is {row parity, column parity}; a blended pair always has one
  // row or column of each parity, so each bank serves exactly one neighbour.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BP = 1'(b >> 1);
    localparam logic BC = 1'(b & 1);
    logic [bis_pkg::ROW_W-1:0] rsel;
    logic [bis_pkg::COL_W-1:0] csel;

    assign rsel = (r0_w[0] == BP) ? r0_w : r1_w;
    assign csel = (c0_w[0] == BC) ? c0_w : c1_w;

    bis_ram #(
      .WIDTH(bis_pkg::PIX_W),
      .DEPTH(bis_pkg::BANK_DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (load_we && (in_row[0] == BP) && (in_col[0] == BC)),
      .waddr(bank_addr(in_row[bis_pkg::ROW_W-1:0], in_col[bis_pkg::COL_W-1:0])),
      .wdata(wdata),
      .re   (state_r == S_ADDR),
      .raddr(bank_addr(rsel, csel)),
      .rdata(rd[b])
    );
  end

  assign lane_ctl.row_en = (state_r == S_READ);
  assign lane_ctl.copy   = copy_r;

  for (genvar k = 0; k < bis_pkg::CHANNELS; k++) begin : g_lane
    bis_lane u_lane (
      .clk     (clk),
      .ctl     (lane_ctl),
      .frac_row(pr_r[15:0]),
      .frac_col(pc_r[15:0]),
      .p00     (rd[{r0p_r, c0p_r}][8*k +: 8]),
      .p10     (rd[{~r0p_r, c0p_r}][8*k +: 8]),
      .p01     (rd[{r0p_r, ~c0p_r}][8*k +: 8]),
      .p11     (rd[{~r0p_r, ~c0p_r}][8*k +: 8]),
      .value   (lane_val[k])
    );
  end

  assign merge_ctl.load = (state_r == S_BLEND);
  assign merge_ctl.err  = err_r;

  bis_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (merge_ctl),
    .lane_val       (lane_val),
    .out_stall      (out_stall),
    .ready          (merge_ready),
    .out_valid      (out_valid),
    .out_chan0      (out_chan0),
    .out_chan1      (out_chan1),
    .out_chan2      (out_chan2),
    .out_chan3      (out_chan3),
    .out_range_error(out_range_error)
  );

endmodule
`default_nettype wire

// File: rtl/bis_checker.sv
`default_nettype none
module bis_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       in_func,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_chan0,
  input wire logic [7:0] out_chan1,
  input wire logic [7:0] out_chan2,
  input wire logic [7:0] out_chan3,
  input wire logic       out_range_error
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_chan0) && $stable(out_chan1) &&
      $stable(out_chan2) && $stable(out_chan3) && $stable(out_range_error))
    else $error("stalled result word changed");

  // An out-of-range request carries all-zero channels.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |->
      out_chan0 == 8'd0 && out_chan1 == 8'd0 && out_chan2 == 8'd0 && out_chan3 == 8'd0)
    else $error("range error word with nonzero channels");

  // A taken request keeps the input stalled while it is in flight.
  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func |=> in_stall)
    else $error("input taken while a request is in flight");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word offered after reset");

endmodule

bind bilinear_image_scaler bis_checker u_bis_checker (.*);
`default_nettype wire

// File: tb/tb_bilinear_image_scaler.sv
module tb_bilinear_image_scaler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [3:0][7:0] chans;
    logic            range_error;
  } pixel_res_t;

  typedef struct {
    bit          err;
    bit          copy;
    int unsigned r0, r1, c0, c1;
    int unsigned fr, fc;
  } src_pos_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_func = 1'b0;
  logic [11:0] in_row = '0;
  logic [11:0] in_col = '0;
  logic [7:0]  in_chan0 = '0;
  logic [7:0]  in_chan1 = '0;
  logic [7:0]  in_chan2 = '0;
  logic [7:0]  in_chan3 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_chan0, out_chan1, out_chan2, out_chan3;
  logic        out_range_error;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  // Shadow copy of the block's registers and frame store.
  logic [8:0]  src_rows_cfg = 9'd256;
  logic [8:0]  src_cols_cfg = 9'd256;
  logic [11:0] tgt_rows_cfg = 12'd256;
  logic [11:0] tgt_cols_cfg = 12'd256;
  logic [19:0] row_step_cfg = 20'd65536;
  logic [19:0] col_step_cfg = 20'd65536;
  bit [31:0]   frame_copy [bis_pkg::MAX_ROWS*bis_pkg::MAX_COLS];
  bit          pixel_written [bis_pkg::MAX_ROWS*bis_pkg::MAX_COLS];

  pixel_res_t  pending_pixels [$];
  int          error_count = 0;
  int          words_sent = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          hold_cycles = 0;

  bilinear_image_scaler u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_chan0        (in_chan0),
    .in_chan1        (in_chan1),
    .in_chan2        (in_chan2),
    .in_chan3        (in_chan3),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_chan0       (out_chan0),
    .out_chan1       (out_chan1),
    .out_chan2       (out_chan2),
    .out_chan3       (out_chan3),
    .out_range_error (out_range_error),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #10ms;
    $display("tb_bilinear_image_scaler: done, errors");
    $finish;
  end

  function automatic src_pos_t locate_source(logic [11:0] row, logic [11:0] col);
    src_pos_t          p;
    longint unsigned   pr, pc;
    int unsigned       last_r, last_c;
    p = '{default: 0};
    if (row >= tgt_rows_cfg || col >= tgt_cols_cfg) begin
      p.err = 1'b1;
      return p;
    end
    // A zero size counts as one row or column, an oversized one as the maximum.
    last_r = (src_rows_cfg == 0) ? 0 :
             (src_rows_cfg > bis_pkg::MAX_ROWS) ? bis_pkg::MAX_ROWS - 1 : src_rows_cfg - 1;
    last_c = (src_cols_cfg == 0) ? 0 :
             (src_cols_cfg > bis_pkg::MAX_COLS) ? bis_pkg::MAX_COLS - 1 : src_cols_cfg - 1;
    pr = longint'(row) * longint'(row_step_cfg);
    pc = longint'(col) * longint'(col_step_cfg);
    p.r0 = 32'(pr >> 16);
    p.fr = 32'(pr & 64'hFFFF);
    p.c0 = 32'(pc >> 16);
    p.fc = 32'(pc & 64'hFFFF);
    if (p.r0 > last_r) p.r0 = last_r;
    if (p.c0 > last_c) p.c0 = last_c;
    p.r1 = p.r0 + ((p.fr != 0) ? 1 : 0);
    p.c1 = p.c0 + ((p.fc != 0) ? 1 : 0);
    if (p.r1 > last_r) p.r1 = last_r;
    if (p.c1 > last_c) p.c1 = last_c;
    p.copy = (p.r0 == p.r1) || (p.c0 == p.c1);
    return p;
  endfunction

  function automatic int unsigned blend(int unsigned frac, int unsigned a, int unsigned b);
    longint unsigned s;
    s = longint'(65536 - frac) * a + longint'(frac) * b;
    return 32'(s >> 16);
  endfunction

  function automatic pixel_res_t predict_pixel(logic [11:0] row, logic [11:0] col);
    src_pos_t    p;
    pixel_res_t  res;
    bit [31:0]   w00, w10, w01, w11;
    int unsigned top, bot;
    p = locate_source(row, col);
    res = '0;
    if (p.err) begin
      res.range_error = 1'b1;
      return res;
    end
    w00 = frame_copy[p.r0*bis_pkg::MAX_COLS + p.c0];
    w10 = frame_copy[p.r1*bis_pkg::MAX_COLS + p.c0];
    w01 = frame_copy[p.r0*bis_pkg::MAX_COLS + p.c1];
    w11 = frame_copy[p.r1*bis_pkg::MAX_COLS + p.c1];
    for (int k = 0; k < 4; k++) begin
      if (p.copy) begin
        res.chans[k] = w00[8*k +: 8];
      end else begin
        top = blend(p.fr, w00[8*k +: 8], w10[8*k +: 8]);
        bot = blend(p.fr, w01[8*k +: 8], w11[8*k +: 8]);
        res.chans[k] = 8'(blend(p.fc, top, bot));
      end
    end
    return res;
  endfunction

  task automatic log_mismatch(string what);
    error_count++;
    if (error_count <= 10) $display("%0t mismatch: %s", $time, what);
  endtask

  // Receiver: random stalls, overridden by a long hold-off when one is armed.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall = 1'b1;
      hold_cycles--;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_result
    pixel_res_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got.chans = {out_chan3, out_chan2, out_chan1, out_chan0};
      got.range_error = out_range_error;
      if (pending_pixels.size() == 0) begin
        log_mismatch($sformatf("result word with nothing expected (%h)", got));
      end else begin
        want = pending_pixels.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (got.chans[k] !== want.chans[k])
            log_mismatch($sformatf("out_chan%0d expected %0d got %0d",
                                   k, want.chans[k], got.chans[k]));
        end
        if (got.range_error !== want.range_error)
          log_mismatch($sformatf("out_range_error expected %0b got %0b",
                                 want.range_error, got.range_error));
      end
    end
  end

  // Offers one word and returns at the edge that takes it; in_valid stays high.
  task automatic send_word(bit func, int unsigned row, int unsigned col,
                           logic [31:0] pix);
    int unsigned idx;
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_func  = func;
    in_row   = 12'(row);
    in_col   = 12'(col);
    {in_chan3, in_chan2, in_chan1, in_chan0} = pix;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    if (func) begin
      pending_pixels.push_back(predict_pixel(12'(row), 12'(col)));
      words_sent++;
    end else if (row < bis_pkg::MAX_ROWS && col < bis_pkg::MAX_COLS) begin
      idx = row*bis_pkg::MAX_COLS + col;
      frame_copy[idx] = pix;
      pixel_written[idx] = 1'b1;
      words_sent++;
    end
  endtask

  // Loads any source pixel the request will read that has not been written yet.
  task automatic request_pixel(int unsigned row, int unsigned col);
    src_pos_t    p;
    int unsigned rr [4];
    int unsigned cc [4];
    int          taps;
    p = locate_source(12'(row), 12'(col));
    taps = p.err ? 0 : (p.copy ? 1 : 4);
    rr = '{p.r0, p.r1, p.r0, p.r1};
    cc = '{p.c0, p.c0, p.c1, p.c1};
    for (int t = 0; t < taps; t++) begin
      if (!pixel_written[rr[t]*bis_pkg::MAX_COLS + cc[t]])
        send_word(1'b0, rr[t], cc[t], $urandom);
    end
    send_word(1'b1, row, col, $urandom);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(bis_pkg::cfg_idx_t idx, int unsigned data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = 20'(data);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bis_pkg::CFG_SRC_ROWS: src_rows_cfg = 9'(data);
      bis_pkg::CFG_SRC_COLS: src_cols_cfg = 9'(data);
      bis_pkg::CFG_TGT_ROWS: tgt_rows_cfg = 12'(data);
      bis_pkg::CFG_TGT_COLS: tgt_cols_cfg = 12'(data);
      bis_pkg::CFG_ROW_STEP: row_step_cfg = 20'(data);
      bis_pkg::CFG_COL_STEP: col_step_cfg = 20'(data);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(int unsigned s_rows, int unsigned s_cols, int unsigned t_rows,
                            int unsigned t_cols, int unsigned r_step, int unsigned c_step);
    wait_idle();
    write_reg(bis_pkg::CFG_SRC_ROWS, s_rows);
    write_reg(bis_pkg::CFG_SRC_COLS, s_cols);
    write_reg(bis_pkg::CFG_TGT_ROWS, t_rows);
    write_reg(bis_pkg::CFG_TGT_COLS, t_cols);
    write_reg(bis_pkg::CFG_ROW_STEP, r_step);
    write_reg(bis_pkg::CFG_COL_STEP, c_step);
  endtask

  function automatic int unsigned pick_src_size();
    case ($urandom_range(9))
      0: return 0;
      1: return bis_pkg::MAX_ROWS;
      2: return $urandom_range(257, 511);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic int unsigned pick_tgt_size();
    case ($urandom_range(9))
      0: return 0;
      1: return 4095;
      2: return $urandom_range(41, 4095);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  function automatic int unsigned pick_step();
    case ($urandom_range(9))
      0: return 4096;
      1: return 20'hFFFFF;
      2, 3: return $urandom_range(4096, 20'hFFFFF);
      default: return $urandom_range(4096, 3*65536);
    endcase
  endfunction

  // Mostly requests with their neighbours loaded first, plus pixel rewrites
  // inside the source frame and some loads and requests that miss entirely.
  task automatic run_burst(int count);
    int          start;
    int unsigned choice, eff_r, eff_c;
    start = words_sent;
    eff_r = (src_rows_cfg == 0) ? 1 :
            (src_rows_cfg > bis_pkg::MAX_ROWS) ? bis_pkg::MAX_ROWS : src_rows_cfg;
    eff_c = (src_cols_cfg == 0) ? 1 :
            (src_cols_cfg > bis_pkg::MAX_COLS) ? bis_pkg::MAX_COLS : src_cols_cfg;
    while (words_sent - start < count) begin
      choice = $urandom_range(99);
      if (choice < 65) begin
        request_pixel((tgt_rows_cfg != 0 && $urandom_range(9) != 0) ?
                        $urandom_range(tgt_rows_cfg - 1) : $urandom_range(4095),
                      (tgt_cols_cfg != 0 && $urandom_range(9) != 0) ?
                        $urandom_range(tgt_cols_cfg - 1) : $urandom_range(4095));
      end else if (choice < 85) begin
        send_word(1'b0, $urandom_range(eff_r - 1), $urandom_range(eff_c - 1), $urandom);
      end else if (choice < 92) begin
        if ($urandom_range(1))
          send_word(1'b0, $urandom_range(bis_pkg::MAX_ROWS, 4095), $urandom_range(4095),
                    $urandom);
        else
          send_word(1'b0, $urandom_range(4095), $urandom_range(bis_pkg::MAX_COLS, 4095),
                    $urandom);
      end else begin
        request_pixel($urandom_range(4095), $urandom_range(4095));
      end
    end
  endtask

  task automatic test_load_and_copy();
    set_config(256, 256, 256, 256, 65536, 65536);
    send_word(1'b0, 0, 0, 32'h00FF00FF);
    send_word(1'b0, 255, 255, 32'hFFFFFFFF);
    send_word(1'b0, 0, 255, 32'h00000000);
    send_word(1'b0, 255, 0, 32'h5AC3A55C);
    // Loads off the store must not alias onto the pixels above.
    send_word(1'b0, 256, 0, 32'h11111111);
    send_word(1'b0, 0, 256, 32'h22222222);
    send_word(1'b0, 4095, 4095, 32'h33333333);
    request_pixel(0, 0);
    request_pixel(255, 255);
    request_pixel(0, 255);
    request_pixel(255, 0);
    request_pixel(256, 5);
    request_pixel(3, 4095);
  endtask

  task automatic test_interpolation();
    set_config(4, 4, 8, 8, 32768, 32768);
    send_word(1'b0, 0, 0, 32'hFFFFFFFF);
    send_word(1'b0, 1, 0, 32'h00000000);
    send_word(1'b0, 0, 1, 32'h00000000);
    send_word(1'b0, 1, 1, 32'hFFFFFFFF);
    request_pixel(1, 1);
    request_pixel(2, 3);
    request_pixel(7, 7);
    // Smallest and largest nonzero fractions.
    set_config(8, 8, 16, 16, 32'h10001, 32'hFFFF);
    request_pixel(1, 1);
    request_pixel(0, 0);
  endtask

  task automatic test_off_target();
    set_config(8, 8, 0, 0, 65536, 65536);
    request_pixel(0, 0);
    request_pixel(5, 5);
    set_config(8, 8, 1, 1, 65536, 65536);
    request_pixel(0, 0);
    request_pixel(0, 1);
    request_pixel(1, 0);
  endtask

  task automatic test_source_clamp();
    // Zero rows count as one, an oversized column count as the maximum, and
    // a base beyond the frame collapses to a copy.
    set_config(0, 511, 4095, 4095, 20'hFFFFF, 4096);
    request_pixel(4095, 4095);
    request_pixel(1, 17);
    request_pixel(0, 0);
    set_config(511, 0, 4095, 4095, 4096, 20'hFFFFF);
    request_pixel(4095, 3);
    request_pixel(17, 1);
  endtask

  task automatic test_random_phases();
    int gap_set   [4] = '{0, 76, 0, 7};
    int stall_set [4] = '{0, 0, 76, 7};
    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < 4; n++) begin
        set_config(pick_src_size(), pick_src_size(), pick_tgt_size(), pick_tgt_size(),
                   pick_step(), pick_step());
        gap_pct   = gap_set[ph];
        stall_pct = stall_set[ph];
        run_burst(85);
      end
    end
    // The widest setting, kept short since nearly every request needs new pixels.
    set_config(256, 256, 4095, 4095, 4096, 4096);
    run_burst(40);
  endtask

  task automatic test_backpressure();
    gap_pct   = 0;
    stall_pct = 20;
    set_config(6, 6, 12, 12, 32768, 32768);
    for (int r = 0; r < 6; r++)
      for (int c = 0; c < 6; c++)
        send_word(1'b0, r, c, $urandom);
    // The receiver holds off while requests keep coming, so the block fills
    // up and raises in_stall.
    hold_cycles = 300;
    for (int i = 0; i < 20; i++)
      request_pixel($urandom_range(11), $urandom_range(11));
    wait_idle();
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 6; j++)
        request_pixel($urandom_range(11), $urandom_range(11));
      wait_idle();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_load_and_copy();
    test_interpolation();
    test_off_target();
    test_source_clamp();
    test_backpressure();
    test_random_phases();
    wait_idle();
    if (error_count == 0 && pending_pixels.size() == 0) begin
      $display("tb_bilinear_image_scaler: done, clean");
    end else begin
      $display("tb_bilinear_image_scaler: done, errors");
    end
    $finish;
  end

endmodule
